// File: design/tsk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_pkg
// Shared constants, cell word layout and CORDIC angle table for the tire
// slip kinematics pipeline.
// ----------------------------------------------------------------------------
package tsk_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int QBITS         = 21;
   localparam int N_CELLS       = (CORDIC_N > QBITS) ? CORDIC_N : QBITS;
   localparam int IDX_W         = $clog2(N_CELLS);
   localparam int QIDX_W        = $clog2(QBITS);

   localparam int CX_W  = 60;
   localparam int CZ_W  = 34;
   localparam int REM_W = 64;
   localparam int DIV_W = 42;

   localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam int HALF_PI_Q14 = 25736;
   localparam int PI_Q14      = 51472;
   localparam int SLIP_LIMIT  = 1048576;

   localparam int RADIUS_W   = 19;
   localparam int THRESH_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_ROLLING_RADIUS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_SPEED     = 1'd1;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      cordic_type        slip;
      cordic_type        camb;
      logic [REM_W-1:0]  rem;
      logic [DIV_W-1:0]  dvs;
      logic [QBITS-1:0]  quo;
      logic              ovf;
      logic              neg;
      logic              low;
   } cell_type;

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [CZ_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return $signed(CZ_W'(v));
   endfunction

endpackage
`default_nettype wire

// File: design/tsk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_front
// Eight-stage front end: rotation matrices, tire-frame velocity and normal,
// speed test, slip numerator/denominator and CORDIC quadrant setup.
// ----------------------------------------------------------------------------
module tsk_front import tsk_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [RADIUS_W-1:0]        rolling_radius,
   input  logic [THRESH_W-1:0]        zero_speed_threshold,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [15:0]         wheel_q0,
   input  logic signed [15:0]         wheel_q1,
   input  logic signed [15:0]         wheel_q2,
   input  logic signed [15:0]         wheel_q3,
   input  logic signed [15:0]         frame_q0,
   input  logic signed [15:0]         frame_q1,
   input  logic signed [15:0]         frame_q2,
   input  logic signed [15:0]         frame_q3,
   input  logic signed [31:0]         vel_x,
   input  logic signed [31:0]         vel_y,
   input  logic signed [31:0]         vel_z,
   input  logic signed [31:0]         spin_rate,
   output logic                       out_valid,
   input  logic                       out_ready,
   output cell_type                   out_data
);

   localparam int FRONT_STAGES = 8;
   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

   typedef struct packed {
      logic signed [31:0] f00, f11, f22, f33, f12, f03, f13, f02, f23, f01;
      logic signed [31:0] w00, w22, w12, w03, w23, w01;
      logic signed [31:0] vx, vy, vz, om;
   } s1_type;

   typedef struct packed {
      logic signed [19:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
      logic signed [19:0] ax, ay, az;
      logic signed [31:0] vx, vy, vz;
      logic signed [51:0] omr;
   } s2_type;

   typedef struct packed {
      logic signed [51:0] a0, a1, a2, b0, b1, b2;
      logic signed [39:0] n0, n1, n2, m0, m1, m2;
      logic signed [51:0] omr;
   } s3_type;

   typedef struct packed {
      logic signed [39:0] tvx, tvy;
      logic signed [41:0] ny, nz;
      logic signed [51:0] omr;
   } s4_type;

   typedef struct packed {
      logic [39:0]        absx;
      logic               low;
      logic signed [57:0] num;
      cordic_type         slip;
      cordic_type         camb;
   } s5_type;

   typedef struct packed {
      logic [39:0] absx;
      logic        low;
      logic [57:0] mag;
      logic        neg;
      cordic_type  slip;
      cordic_type  camb;
   } s6_type;

   typedef struct packed {
      logic [REM_W-1:0] nval;
      logic [DIV_W-1:0] dvs;
      logic             neg;
      logic             low;
      cordic_type       slip;
      cordic_type       camb;
   } s7_type;

   function automatic logic signed [19:0] rnd14(input logic signed [35:0] t);
      logic signed [35:0] s;
      s = t + 36'sd8192;
      return s[33:14];
   endfunction

   function automatic cordic_type prerot(input logic signed [CX_W-1:0] x,
                                         input logic signed [CX_W-1:0] y);
      cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = HALF_PI_Q30;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -HALF_PI_Q30;
         end
      end
      return c;
   endfunction

   logic [FRONT_STAGES-1:0] vld_ff;
   logic [FRONT_STAGES-1:0] acc;

   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   s4_type   s4_ff, s4_in;
   s5_type   s5_ff, s5_in;
   s6_type   s6_ff, s6_in;
   s7_type   s7_ff, s7_in;
   cell_type s8_ff, s8_in;

   // a stage loads when it is empty or the next one loads
   always_comb begin
      acc[FRONT_STAGES-1] = !vld_ff[FRONT_STAGES-1] || out_ready;
      for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
         acc[k] = !vld_ff[k] || acc[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (acc[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            if (acc[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1: quaternion products
   always_comb begin
      s1_in.f00 = frame_q0 * frame_q0;
      s1_in.f11 = frame_q1 * frame_q1;
      s1_in.f22 = frame_q2 * frame_q2;
      s1_in.f33 = frame_q3 * frame_q3;
      s1_in.f12 = frame_q1 * frame_q2;
      s1_in.f03 = frame_q0 * frame_q3;
      s1_in.f13 = frame_q1 * frame_q3;
      s1_in.f02 = frame_q0 * frame_q2;
      s1_in.f23 = frame_q2 * frame_q3;
      s1_in.f01 = frame_q0 * frame_q1;
      s1_in.w00 = wheel_q0 * wheel_q0;
      s1_in.w22 = wheel_q2 * wheel_q2;
      s1_in.w12 = wheel_q1 * wheel_q2;
      s1_in.w03 = wheel_q0 * wheel_q3;
      s1_in.w23 = wheel_q2 * wheel_q3;
      s1_in.w01 = wheel_q0 * wheel_q1;
      s1_in.vx  = vel_x;
      s1_in.vy  = vel_y;
      s1_in.vz  = vel_z;
      s1_in.om  = spin_rate;
   end

   // stage 2: matrix entries in Q.14, wheel axis, omega*R
   always_comb begin
      s2_in.r00 = rnd14((36'(s1_ff.f00) + 36'(s1_ff.f11)) * 2 - ONE_Q28);
      s2_in.r01 = rnd14((36'(s1_ff.f12) - 36'(s1_ff.f03)) * 2);
      s2_in.r02 = rnd14((36'(s1_ff.f13) + 36'(s1_ff.f02)) * 2);
      s2_in.r10 = rnd14((36'(s1_ff.f12) + 36'(s1_ff.f03)) * 2);
      s2_in.r11 = rnd14((36'(s1_ff.f00) + 36'(s1_ff.f22)) * 2 - ONE_Q28);
      s2_in.r12 = rnd14((36'(s1_ff.f23) - 36'(s1_ff.f01)) * 2);
      s2_in.r20 = rnd14((36'(s1_ff.f13) - 36'(s1_ff.f02)) * 2);
      s2_in.r21 = rnd14((36'(s1_ff.f23) + 36'(s1_ff.f01)) * 2);
      s2_in.r22 = rnd14((36'(s1_ff.f00) + 36'(s1_ff.f33)) * 2 - ONE_Q28);
      s2_in.ax  = rnd14((36'(s1_ff.w12) - 36'(s1_ff.w03)) * 2);
      s2_in.ay  = rnd14((36'(s1_ff.w00) + 36'(s1_ff.w22)) * 2 - ONE_Q28);
      s2_in.az  = rnd14((36'(s1_ff.w23) + 36'(s1_ff.w01)) * 2);
      s2_in.vx  = s1_ff.vx;
      s2_in.vy  = s1_ff.vy;
      s2_in.vz  = s1_ff.vz;
      s2_in.omr = s1_ff.om * $signed({1'b0, rolling_radius});
   end

   // stage 3: transposed-rotation products
   always_comb begin
      s3_in.a0  = s2_ff.r00 * s2_ff.vx;
      s3_in.a1  = s2_ff.r10 * s2_ff.vy;
      s3_in.a2  = s2_ff.r20 * s2_ff.vz;
      s3_in.b0  = s2_ff.r01 * s2_ff.vx;
      s3_in.b1  = s2_ff.r11 * s2_ff.vy;
      s3_in.b2  = s2_ff.r21 * s2_ff.vz;
      s3_in.n0  = s2_ff.r01 * s2_ff.ax;
      s3_in.n1  = s2_ff.r11 * s2_ff.ay;
      s3_in.n2  = s2_ff.r21 * s2_ff.az;
      s3_in.m0  = s2_ff.r02 * s2_ff.ax;
      s3_in.m1  = s2_ff.r12 * s2_ff.ay;
      s3_in.m2  = s2_ff.r22 * s2_ff.az;
      s3_in.omr = s2_ff.omr;
   end

   // stage 4: sums
   always_comb begin
      logic signed [53:0] sx, sy;
      sx = 54'(s3_ff.a0) + 54'(s3_ff.a1) + 54'(s3_ff.a2) + 54'sd8192;
      sy = 54'(s3_ff.b0) + 54'(s3_ff.b1) + 54'(s3_ff.b2) + 54'sd8192;
      s4_in.tvx = sx[53:14];
      s4_in.tvy = sy[53:14];
      s4_in.ny  = 42'(s3_ff.n0) + 42'(s3_ff.n1) + 42'(s3_ff.n2);
      s4_in.nz  = 42'(s3_ff.m0) + 42'(s3_ff.m1) + 42'(s3_ff.m2);
      s4_in.omr = s3_ff.omr;
   end

   // stage 5: |Vx|, speed test, slip numerator, CORDIC setup
   always_comb begin
      logic [39:0] ax;
      ax = (s4_ff.tvx < 0) ? 40'(-s4_ff.tvx) : 40'(s4_ff.tvx);
      s5_in.absx = ax;
      s5_in.low  = ax <= 40'(zero_speed_threshold);
      s5_in.num  = 58'(s4_ff.omr) - (58'(s4_ff.tvx) <<< 16);
      s5_in.slip = prerot(CX_W'($signed({1'b0, ax})) <<< 16, CX_W'(s4_ff.tvy) <<< 16);
      s5_in.camb = prerot(CX_W'(s4_ff.ny) <<< 16, CX_W'(s4_ff.nz) <<< 16);
   end

   // stage 6: magnitude of numerator
   always_comb begin
      s6_in.absx = s5_ff.absx;
      s6_in.low  = s5_ff.low;
      s6_in.neg  = s5_ff.num < 0;
      s6_in.mag  = (s5_ff.num < 0) ? 58'(-s5_ff.num) : 58'(s5_ff.num);
      s6_in.slip = s5_ff.slip;
      s6_in.camb = s5_ff.camb;
   end

   // stage 7: rounded dividend and divisor 4|Vx|
   always_comb begin
      s7_in.nval = REM_W'(s6_ff.mag) + (REM_W'(s6_ff.absx) << 1);
      s7_in.dvs  = DIV_W'(s6_ff.absx) << 2;
      s7_in.neg  = s6_ff.neg;
      s7_in.low  = s6_ff.low;
      s7_in.slip = s6_ff.slip;
      s7_in.camb = s6_ff.camb;
   end

   // stage 8: quotient overflow test
   always_comb begin
      s8_in.slip = s7_ff.slip;
      s8_in.camb = s7_ff.camb;
      s8_in.rem  = s7_ff.nval;
      s8_in.dvs  = s7_ff.dvs;
      s8_in.quo  = '0;
      s8_in.ovf  = s7_ff.nval >= (REM_W'(s7_ff.dvs) << QBITS);
      s8_in.neg  = s7_ff.neg;
      s8_in.low  = s7_ff.low;
   end

   always_ff @(posedge clock) begin
      if (acc[0]) s1_ff <= s1_in;
      if (acc[1]) s2_ff <= s2_in;
      if (acc[2]) s3_ff <= s3_in;
      if (acc[3]) s4_ff <= s4_in;
      if (acc[4]) s5_ff <= s5_in;
      if (acc[5]) s6_ff <= s6_in;
      if (acc[6]) s7_ff <= s7_in;
      if (acc[7]) s8_ff <= s8_in;
   end

   assign in_ready  = acc[0];
   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_data  = s8_ff;

endmodule
`default_nettype wire

// File: design/tsk_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_cell
// One cell of the row: a CORDIC vectoring step for both angles below CORDIC_N,
// a restoring-division quotient bit below QBITS, registered with own valid.
// ----------------------------------------------------------------------------
module tsk_cell import tsk_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] stage_idx,
   input  logic             in_valid,
   output logic             in_ready,
   input  cell_type         in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cell_type         out_data
);

   function automatic cordic_type rot(input cordic_type c, input logic [IDX_W-1:0] i);
      cordic_type r;
      logic signed [CX_W-1:0] dx, dy;
      r  = c;
      dx = c.y >>> i;
      dy = c.x >>> i;
      if (c.y > 0) begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + atan_q30(i);
      end else if (c.y < 0) begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - atan_q30(i);
      end
      return r;
   endfunction

   logic      valid_ff;
   cell_type  data_ff, data_in;

   always_comb begin
      logic [IDX_W-1:0]  qb_wide;
      logic [QIDX_W-1:0] qb;
      logic [REM_W-1:0]  trial;
      data_in = in_data;
      qb_wide = IDX_W'(QBITS - 1) - stage_idx;
      qb      = qb_wide[QIDX_W-1:0];
      trial   = REM_W'(in_data.dvs) << qb;
      if (stage_idx < IDX_W'(CORDIC_N)) begin
         data_in.slip = rot(in_data.slip, stage_idx);
         data_in.camb = rot(in_data.camb, stage_idx);
      end
      if (stage_idx < IDX_W'(QBITS)) begin
         if (in_data.rem >= trial) begin
            data_in.rem     = in_data.rem - trial;
            data_in.quo[qb] = 1'b1;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// File: design/tsk_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsk_back
// Output register: angle rounding and clamping, slip sign and saturation,
// low-speed override.
// ----------------------------------------------------------------------------
module tsk_back import tsk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cell_type           in_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_slip_angle,
   output logic signed [21:0] rsp_longitudinal_slip,
   output logic signed [16:0] rsp_camber_angle,
   output logic               rsp_low_speed,
   output logic               rsp_slip_clipped
);

   localparam logic signed [CZ_W-1:0] RND_HALF = CZ_W'(32768);

   logic               valid_ff;
   logic signed [15:0] slip_angle_ff, slip_angle_in;
   logic signed [21:0] long_slip_ff, long_slip_in;
   logic signed [16:0] camber_ff, camber_in;
   logic               low_ff, low_in;
   logic               clip_ff, clip_in;

   always_comb begin
      logic signed [CZ_W-1:0] za, zc;
      logic [21:0]            qmag;
      logic                   over;
      za = (in_data.slip.z + RND_HALF) >>> 16;
      zc = (in_data.camb.z + RND_HALF) >>> 16;
      over = in_data.ovf || (in_data.quo > QBITS'(SLIP_LIMIT));
      qmag = over ? 22'(SLIP_LIMIT) : {1'b0, in_data.quo};

      if (za > HALF_PI_Q14)       slip_angle_in = 16'(HALF_PI_Q14);
      else if (za < -HALF_PI_Q14) slip_angle_in = 16'(-HALF_PI_Q14);
      else                        slip_angle_in = za[15:0];

      if (zc > PI_Q14)            camber_in = 17'(PI_Q14);
      else if (zc < -PI_Q14)      camber_in = 17'(-PI_Q14);
      else                        camber_in = zc[16:0];

      long_slip_in = in_data.neg ? -qmag : qmag;
      clip_in      = over;
      low_in       = in_data.low;
      // at or below the speed threshold only camber is meaningful
      if (in_data.low) begin
         slip_angle_in = '0;
         long_slip_in  = '0;
         clip_in       = 1'b0;
      end
   end

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         slip_angle_ff <= slip_angle_in;
         long_slip_ff  <= long_slip_in;
         camber_ff     <= camber_in;
         low_ff        <= low_in;
         clip_ff       <= clip_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_slip_angle        = slip_angle_ff;
   assign rsp_longitudinal_slip = long_slip_ff;
   assign rsp_camber_angle      = camber_ff;
   assign rsp_low_speed         = low_ff;
   assign rsp_slip_clipped      = clip_ff;

endmodule
`default_nettype wire

// File: design/tire_slip_kinematics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tire_slip_kinematics_top
// Slip angle, longitudinal slip and camber from wheel and tire-frame
// quaternions, world velocity and spin rate.
// ----------------------------------------------------------------------------
//  port group | direction | handshake             | carries
//  req_*      | in        | req_valid / req_ready | wheel/frame quaternion, velocity, spin
//  rsp_*      | out       | rsp_valid / rsp_ready | slip angle, slip ratio, camber, flags
//  csr_*      | in        | csr_write_en          | rolling_radius, zero_speed_threshold
//
//  One word per cycle sustained while rsp_ready is held high. The path runs
//  through 8 front-end stages, N_CELLS cells (the longer of the CORDIC row and
//  the 21-bit quotient row) and the output register.
//  Every stage holds its own valid, so bubbles close up and input keeps
//  flowing while a result waits at rsp_*, until every stage is full. Reset
//  clears valids and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module tire_slip_kinematics_top import tsk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_wheel_q0,
   input  logic signed [15:0]    req_wheel_q1,
   input  logic signed [15:0]    req_wheel_q2,
   input  logic signed [15:0]    req_wheel_q3,
   input  logic signed [15:0]    req_frame_q0,
   input  logic signed [15:0]    req_frame_q1,
   input  logic signed [15:0]    req_frame_q2,
   input  logic signed [15:0]    req_frame_q3,
   input  logic signed [31:0]    req_vel_x,
   input  logic signed [31:0]    req_vel_y,
   input  logic signed [31:0]    req_vel_z,
   input  logic signed [31:0]    req_spin_rate,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_slip_angle,
   output logic signed [21:0]    rsp_longitudinal_slip,
   output logic signed [16:0]    rsp_camber_angle,
   output logic                  rsp_low_speed,
   output logic                  rsp_slip_clipped
);

   logic [RADIUS_W-1:0] rolling_radius_ff;
   logic [THRESH_W-1:0] zero_speed_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rolling_radius_ff       <= RADIUS_W'(32768);
         zero_speed_threshold_ff <= THRESH_W'(7);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ROLLING_RADIUS: rolling_radius_ff       <= csr_wdata[RADIUS_W-1:0];
            CSR_ZERO_SPEED:     zero_speed_threshold_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   logic     cv   [N_CELLS+1];
   logic     crdy [N_CELLS+1];
   cell_type cd   [N_CELLS+1];

   tsk_front u_front (
      .clock                (clock),
      .reset                (reset),
      .rolling_radius       (rolling_radius_ff),
      .zero_speed_threshold (zero_speed_threshold_ff),
      .in_valid             (req_valid),
      .in_ready             (req_ready),
      .wheel_q0             (req_wheel_q0),
      .wheel_q1             (req_wheel_q1),
      .wheel_q2             (req_wheel_q2),
      .wheel_q3             (req_wheel_q3),
      .frame_q0             (req_frame_q0),
      .frame_q1             (req_frame_q1),
      .frame_q2             (req_frame_q2),
      .frame_q3             (req_frame_q3),
      .vel_x                (req_vel_x),
      .vel_y                (req_vel_y),
      .vel_z                (req_vel_z),
      .spin_rate            (req_spin_rate),
      .out_valid            (cv[0]),
      .out_ready            (crdy[0]),
      .out_data             (cd[0])
   );

   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      tsk_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (IDX_W'(k)),
         .in_valid  (cv[k]),
         .in_ready  (crdy[k]),
         .in_data   (cd[k]),
         .out_valid (cv[k+1]),
         .out_ready (crdy[k+1]),
         .out_data  (cd[k+1])
      );
   end

   tsk_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (cv[N_CELLS]),
      .in_ready              (crdy[N_CELLS]),
      .in_data               (cd[N_CELLS]),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_slip_angle        (rsp_slip_angle),
      .rsp_longitudinal_slip (rsp_longitudinal_slip),
      .rsp_camber_angle      (rsp_camber_angle),
      .rsp_low_speed         (rsp_low_speed),
      .rsp_slip_clipped      (rsp_slip_clipped)
   );

   a_low_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_low_speed |->
         rsp_slip_angle == 16'sd0 && rsp_longitudinal_slip == 22'sd0 && !rsp_slip_clipped)
      else $error("slip nonzero at low speed");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slip_clipped |->
         rsp_longitudinal_slip == 22'(SLIP_LIMIT) || rsp_longitudinal_slip == 22'(-SLIP_LIMIT))
      else $error("clipped slip not at limit");

   a_slip_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slip_angle <= 16'sd25736 && rsp_slip_angle >= -16'sd25736)
      else $error("slip angle out of range");

endmodule
`default_nettype wire
